// ===== rtl/tfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_W   = 16;
    localparam int NORM_FRAC = 14;
    localparam int NORM_W    = NORM_FRAC + 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] middle_x;
        logic signed [COORD_W-1:0] middle_y;
        logic signed [COORD_W-1:0] middle_z;
        logic signed [COORD_W-1:0] last_x;
        logic signed [COORD_W-1:0] last_y;
        logic signed [COORD_W-1:0] last_z;
    } t_tri;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic                     degenerate;
    } t_norm;

endpackage

// ===== rtl/tfn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_tri_if / tfn_norm_if
// Valid/ready channels for triangle words and normal words.
// ----------------------------------------------------------------------------
interface tfn_tri_if;
    logic          valid;
    logic          ready;
    tfn_pkg::t_tri data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tfn_norm_if;
    logic           valid;
    logic           ready;
    tfn_pkg::t_norm data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/triangle_face_normal_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle: edges, exact cross product, prescale,
// pipelined integer square root and per-component restoring divide.
// ----------------------------------------------------------------------------
// One triangle word may be accepted every clock unless the output stalls; one
// normal word comes out for each, in order. Between input and output lie the
// registers for edges, products, cross, prescale and squares, the square root
// (one result bit per stage), the divide (one quotient bit per stage) and the
// output register. The whole pipeline advances together and holds while the
// output register is full and not taken; it is one long chain of registers, so
// throughput is set only by the output handshake.
module triangle_face_normal_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfn_tri_if.sink     i_tri,
    tfn_norm_if.source  o_norm
);

    localparam int NF  = tfn_pkg::NORM_FRAC;
    localparam int CW  = tfn_pkg::COORD_W;
    localparam int EW  = CW + 1;          // edge width
    localparam int PW  = 2 * EW;          // product width
    localparam int XW  = PW + 1;          // cross magnitude width
    localparam int MW  = 31;              // prescaled magnitude
    localparam int SW  = 2 * MW + 2;      // sum of squares width
    localparam int RW  = SW / 2;          // root width (32)
    localparam int QB  = NF + 2;          // quotient bits
    localparam int NW  = tfn_pkg::NORM_W;
    localparam int DS  = QB + 1;          // divide taps incl. unregistered input
    localparam int LAT = 4 + RW + DS + 1;

    logic adv;
    assign adv = !o_norm.valid || o_norm.ready;
    assign i_tri.ready = adv;

    // valid chain
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_tri.valid};
        end
    end

    // stage 1: edges
    logic signed [EW-1:0] r_a[3], r_b[3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a[0] <= EW'(i_tri.data.last_x)  - EW'(i_tri.data.middle_x);
            r_a[1] <= EW'(i_tri.data.last_y)  - EW'(i_tri.data.middle_y);
            r_a[2] <= EW'(i_tri.data.last_z)  - EW'(i_tri.data.middle_z);
            r_b[0] <= EW'(i_tri.data.first_x) - EW'(i_tri.data.middle_x);
            r_b[1] <= EW'(i_tri.data.first_y) - EW'(i_tri.data.middle_y);
            r_b[2] <= EW'(i_tri.data.first_z) - EW'(i_tri.data.middle_z);
        end
    end

    // stage 2: products
    logic signed [PW-1:0] r_p[6];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p[0] <= r_a[1] * r_b[2]; r_p[1] <= r_a[2] * r_b[1];
            r_p[2] <= r_a[2] * r_b[0]; r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1]; r_p[5] <= r_a[1] * r_b[0];
        end
    end

    // stage 3: cross product as sign and magnitude
    logic [XW-1:0] r_cm[3];
    logic [2:0]    r_cn;
    always_ff @(posedge i_clk) begin
        logic signed [XW-1:0] d;
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                d = XW'(r_p[2*i]) - XW'(r_p[2*i+1]);
                r_cn[i] <= d[XW-1];
                r_cm[i] <= d[XW-1] ? XW'(-d) : XW'(d);
            end
        end
    end

    // stage 4: prescale so every magnitude fits 31 bits
    logic [MW-1:0] r_m[3];
    logic [2:0]    r_sn;
    logic [XW-1:0] orm;
    logic [$clog2(XW)-1:0] sh;
    always_comb begin
        orm = r_cm[0] | r_cm[1] | r_cm[2];
        sh = '0;
        for (int k = MW; k < XW; k++) begin
            if (orm[k]) sh = $clog2(XW)'(k - MW + 1);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) r_m[i] <= MW'(r_cm[i] >> sh);
            r_sn <= r_cn;
        end
    end

    // stage 5: squares summed (register holds sum)
    logic [SW-1:0] r_sum;
    logic [MW-1:0] r_m5[3];
    logic [2:0]    r_sn5;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum <= SW'(r_m[0] * r_m[0]) + SW'(r_m[1] * r_m[1]) + SW'(r_m[2] * r_m[2]);
            r_m5  <= r_m;
            r_sn5 <= r_sn;
        end
    end

    // square root: one result bit per stage, shift and subtract
    logic [SW-1:0] r_rem[RW+1];
    logic [SW-1:0] r_root[RW+1];
    logic [MW-1:0] r_sm[RW+1][3];
    logic [2:0]    r_ssn[RW+1];
    logic          r_zero[RW+1];
    assign r_rem[0]  = r_sum;
    assign r_root[0] = '0;
    assign r_sm[0]   = r_m5;
    assign r_ssn[0]  = r_sn5;
    assign r_zero[0] = (r_sum == '0);
    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        localparam logic [SW-1:0] PLACE = SW'(1) << (SW - 2 - 2 * g);
        logic [SW-1:0] r_rem_q;
        logic [SW-1:0] r_root_q;
        logic [MW-1:0] r_sm_q[3];
        logic [2:0]    r_ssn_q;
        logic          r_zero_q;
        logic [SW-1:0] trial;
        logic          take;
        always_comb begin
            trial = r_root[g] + PLACE;
            take  = (r_rem[g] >= trial);
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (take) begin
                    r_rem_q  <= r_rem[g] - trial;
                    r_root_q <= (r_root[g] >> 1) + PLACE;
                end else begin
                    r_rem_q  <= r_rem[g];
                    r_root_q <= r_root[g] >> 1;
                end
                r_sm_q   <= r_sm[g];
                r_ssn_q  <= r_ssn[g];
                r_zero_q <= r_zero[g];
            end
        end
        assign r_rem[g+1]  = r_rem_q;
        assign r_root[g+1] = r_root_q;
        assign r_sm[g+1]   = r_sm_q;
        assign r_ssn[g+1]  = r_ssn_q;
        assign r_zero[g+1] = r_zero_q;
    end

    // restoring divide: q = floor((m<<(F+1) + L) / 2L), one bit per stage
    localparam int DW = MW + NF + 2;
    logic [DW-1:0] r_num[DS][3];
    logic [QB-1:0] r_q[DS][3];
    logic [RW:0]   r_den[DS];
    logic [2:0]    r_dsn[DS];
    logic          r_dz[DS];
    assign r_den[0] = {r_root[RW][RW-1:0], 1'b0};
    assign r_dsn[0] = r_ssn[RW];
    assign r_dz[0]  = r_zero[RW];
    for (genvar i = 0; i < 3; i++) begin : g_div_in
        assign r_num[0][i] = (DW'(r_sm[RW][i]) << (NF + 1)) + DW'(r_root[RW][RW-1:0]);
        assign r_q[0][i]   = '0;
    end
    for (genvar g = 0; g < DS - 1; g++) begin : g_div
        logic [DW-1:0] r_num_q[3];
        logic [QB-1:0] r_q_q[3];
        logic [RW:0]   r_den_q;
        logic [2:0]    r_dsn_q;
        logic          r_dz_q;
        localparam int B = QB - 1 - g;
        always_ff @(posedge i_clk) begin
            logic [DW+QB:0] t;
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    t = (DW + QB + 1)'(r_den[g]) << B;
                    if (t <= (DW + QB + 1)'(r_num[g][i])) begin
                        r_num_q[i] <= r_num[g][i] - DW'(t);
                        r_q_q[i]   <= r_q[g][i] | (QB'(1) << B);
                    end else begin
                        r_num_q[i] <= r_num[g][i];
                        r_q_q[i]   <= r_q[g][i];
                    end
                end
                r_den_q <= r_den[g];
                r_dsn_q <= r_dsn[g];
                r_dz_q  <= r_dz[g];
            end
        end
        assign r_num[g+1] = r_num_q;
        assign r_q[g+1]   = r_q_q;
        assign r_den[g+1] = r_den_q;
        assign r_dsn[g+1] = r_dsn_q;
        assign r_dz[g+1]  = r_dz_q;
    end

    // output word register
    tfn_pkg::t_norm r_out, n_out;
    logic [NW-1:0] qs[3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qs[i] = r_dsn[DS-1][i] ? NW'(-NW'(r_q[DS-1][i])) : NW'(r_q[DS-1][i]);
            if (r_dz[DS-1]) qs[i] = '0;
        end
        n_out.normal_x   = qs[0];
        n_out.normal_y   = qs[1];
        n_out.normal_z   = qs[2];
        n_out.degenerate = r_dz[DS-1];
    end
    always_ff @(posedge i_clk) begin
        if (adv) r_out <= n_out;
    end
    assign o_norm.data  = r_out;
    assign o_norm.valid = r_vld[LAT-1];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_norm.valid && !o_norm.ready |=> $stable(o_norm.data))
        else $error("output word changed under stall");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_norm.valid && o_norm.data.degenerate |-> o_norm.data.normal_x == '0 &&
        o_norm.data.normal_y == '0 && o_norm.data.normal_z == '0)
        else $error("degenerate word with nonzero normal");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_norm.valid |-> i_tri.ready)
        else $error("input stalled with empty output");
`endif

endmodule
